// File: hdl/irl_pkg.sv
// Package with shared types and constants for the indexed ring list.
`timescale 1ns / 1ps

package irl_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int POS_W     = $clog2(CAPACITY + 1);

    localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(CAPACITY);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT_AT = 3'd1,
        OP_REMOVE_AT = 3'd2,
        OP_READ_AT   = 3'd3,
        OP_FIND      = 3'd4,
        OP_REMOVE_VAL = 3'd5,
        OP_DEQUEUE   = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Per-cell move commands; at most one is set in a cycle.
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
    } cell_ctrl_t;

endpackage

// File: hdl/irl_cell.sv
// One storage cell of the list: holds one entry and compares it with the request word.
`timescale 1ns / 1ps

module irl_cell (
    input  logic               clk,
    input  irl_pkg::cell_ctrl_t ctrl,
    input  irl_pkg::word_t     lower_word,
    input  irl_pkg::word_t     upper_word,
    input  irl_pkg::word_t     value,
    output irl_pkg::word_t     word,
    output logic               match
);
    import irl_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            word_next = value;
        end
        else if (ctrl.shift_up)
        begin
            word_next = lower_word;
        end
        else if (ctrl.shift_down)
        begin
            word_next = upper_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == value);

endmodule

// File: hdl/irl_chain.sv
// Row of list cells, each linked to its neighbors for insert and remove shifts.
`timescale 1ns / 1ps

module irl_chain (
    input  logic                                       clk,
    input  irl_pkg::cell_ctrl_t [irl_pkg::CAPACITY-1:0] ctrl,
    input  irl_pkg::word_t                             value,
    output irl_pkg::word_t [irl_pkg::CAPACITY-1:0]     words,
    output logic [irl_pkg::CAPACITY-1:0]               cell_match
);
    import irl_pkg::*;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t lower_word;
        word_t upper_word;

        if (i == 0)
        begin : g_first
            assign lower_word = '0;
        end
        else
        begin : g_mid_lo
            assign lower_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_word = '0;
        end
        else
        begin : g_mid_hi
            assign upper_word = words[i+1];
        end

        irl_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .lower_word (lower_word),
            .upper_word (upper_word),
            .value      (value),
            .word       (words[i]),
            .match      (cell_match[i])
        );
    end

endmodule

// File: hdl/indexed_ring_list.sv
// Top level of the indexed ring list: request decode, cell control and result register.
`timescale 1ns / 1ps

// The list keeps up to 16 words in a row of cells ordered by logical position, cell 0
// being the head. Every request beat (append, insert at, remove at, read at, find,
// remove by value, dequeue, clear) is finished in the cycle it is accepted: the cells
// shift toward or away from the affected position in one step, and find compares all
// cells at once and takes the lowest match below the entry count. One request is taken
// per cycle; the result beat is registered in an output register, and a new request is
// accepted whenever that register is empty or is being drained. Fields that come from
// slots never written are not defined, but only written entries are read.

module indexed_ring_list (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [2:0]                       operation,
    input  logic [irl_pkg::POS_W-1:0]        position,
    input  logic [irl_pkg::WORD_BITS-1:0]    value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [irl_pkg::WORD_BITS-1:0]    data_out,
    output logic [irl_pkg::IDX_W-1:0]        found_position,
    output logic [irl_pkg::POS_W-1:0]        entry_count
);
    import irl_pkg::*;

    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    word_t            data_reg;
    word_t            data_next;
    logic [IDX_W-1:0] found_reg;
    logic [IDX_W-1:0] found_next;
    logic [POS_W-1:0] entry_count_reg;

    logic                            in_accept;
    op_t                             op;
    cell_ctrl_t [CAPACITY-1:0]       ctrl;
    word_t [CAPACITY-1:0]            words;
    logic [CAPACITY-1:0]             cell_match;
    logic [CAPACITY-1:0]             hits;
    logic                            hit_any;
    logic [IDX_W-1:0]                first_hit;
    logic                            do_insert;
    logic                            do_remove;
    logic [POS_W-1:0]                sel_pos;

    assign op        = op_t'(operation);
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    irl_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .value      (value),
        .words      (words),
        .cell_match (cell_match)
    );

    // Only cells below the entry count take part in a search.
    always_comb
    begin
        hit_any   = 1'b0;
        first_hit = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hits[i] = cell_match[i] && (POS_W'(i) < count_reg);
        end
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_any   = 1'b1;
                first_hit = IDX_W'(i);
            end
        end
    end

    // Request decode: status, result fields and which list edit takes place.
    always_comb
    begin
        status_next = ST_DONE;
        data_next   = '0;
        found_next  = '0;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        sel_pos     = position;
        count_next  = count_reg;

        unique case (op)
            OP_APPEND:
            begin
                sel_pos = count_reg;
                if (count_reg >= FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_INSERT_AT:
            begin
                if (position > count_reg)
                begin
                    status_next = ST_MISS;
                end
                else if (count_reg >= FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                end
            end
            OP_REMOVE_AT:
            begin
                if (position >= count_reg)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    do_remove = 1'b1;
                    data_next = words[position[IDX_W-1:0]];
                end
            end
            OP_READ_AT:
            begin
                if (position >= count_reg)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    data_next = words[position[IDX_W-1:0]];
                end
            end
            OP_FIND:
            begin
                if (!hit_any)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    found_next = first_hit;
                end
            end
            OP_REMOVE_VAL:
            begin
                sel_pos = POS_W'(first_hit);
                if (!hit_any)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    found_next = first_hit;
                    do_remove  = 1'b1;
                    // The removed entry equals the request word by definition.
                    data_next  = value;
                end
            end
            OP_DEQUEUE:
            begin
                sel_pos = '0;
                if (count_reg == '0)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    do_remove = 1'b1;
                    data_next = words[0];
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase

        if (do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Insert shifts cells above the position and loads the word; remove shifts it and above.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].load       = in_accept && do_insert && (POS_W'(i) == sel_pos);
            ctrl[i].shift_up   = in_accept && do_insert && (POS_W'(i) > sel_pos);
            ctrl[i].shift_down = in_accept && do_remove && (POS_W'(i) >= sel_pos);
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg      <= status_next;
            data_reg        <= data_next;
            found_reg       <= found_next;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign data_out       = data_reg;
    assign found_position = found_reg;
    assign entry_count    = entry_count_reg;

    ap_count_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT
    ) else $error("entry count above capacity");

    ap_full_only_at_capacity: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> (entry_count_reg == FULL_COUNT)
    ) else $error("full status reported below capacity");

    ap_miss_keeps_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && status_next == ST_MISS) |=> (count_reg == $past(count_reg))
    ) else $error("count changed on a missed request");

    ap_remove_decrements: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && do_remove) |=> (count_reg == $past(count_reg) - 1'b1)
    ) else $error("remove did not drop the count by one");

    ap_edit_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(do_insert && do_remove) && !(do_remove && status_next != ST_DONE)
    ) else $error("conflicting list edits in one request");

endmodule
